// ----- rtl/core/assert_macros.svh -----
// Assertion helper macros for the ADTS frame synchroniser core.
// Plain text header, no dependencies; modules take it by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define AFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define AFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/afs_pkg.sv -----
// Shared types and constants for the ADTS frame synchroniser.
// No dependencies; used by every module of the core.
package afs_pkg;

  localparam int unsigned HdrBytes      = 6;
  localparam int unsigned LenW          = 13;
  localparam int unsigned QueueDepthDef = 8;

  localparam logic [7:0]      SyncByte = 8'hFF;
  localparam logic [7:0]      SyncMask = 8'hF0;
  localparam logic [LenW-1:0] MinLen   = 13'd7;

  typedef enum logic [1:0] {
    PhHunt    = 2'd0,
    PhSync2   = 2'd1,
    PhHeader  = 2'd2,
    PhPayload = 2'd3
  } phase_e;

  typedef enum logic {
    KindHeader  = 1'b0,
    KindPayload = 1'b1
  } kind_e;

  // One queue entry: a whole header (six bytes out) or one payload byte
  // (in bytes[0]).
  typedef struct packed {
    kind_e                        kind;
    logic [HdrBytes-1:0][7:0]     bytes;
    logic                         last;
    logic [LenW-1:0]              len;
  } entry_t;

endpackage

// ----- rtl/core/afs_front.sv -----
// Front end: sync hunt, header capture, length decode, queue entry build.
// Depends on afs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module afs_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [7:0]      data_i,
  input  logic            full_i,
  output logic            push_o,
  output afs_pkg::entry_t entry_o
);

  localparam int unsigned HdrStore = afs_pkg::HdrBytes - 1;
  localparam int unsigned LenW     = afs_pkg::LenW;

  afs_pkg::phase_e phase_q, phase_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0] flen_q, flen_d;
  logic [7:0]      hdr_q [HdrStore];
  logic            hdr_we;
  logic [2:0]      hdr_wa;
  logic            accept;
  logic [LenW-1:0] len_dec;
  logic [LenW-1:0] cnt_inc;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  // 13-bit aac_frame_length: byte3[1:0], byte4, byte5[7:5]
  assign len_dec = {hdr_q[3][1:0], hdr_q[4], data_i[7:5]};
  assign cnt_inc = cnt_q + LenW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= afs_pkg::PhHunt;
      cnt_q   <= '0;
      flen_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      flen_q  <= flen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[hdr_wa] <= data_i;
    end
  end

  always_comb begin
    phase_d       = phase_q;
    cnt_d         = cnt_q;
    flen_d        = flen_q;
    hdr_we        = 1'b0;
    hdr_wa        = cnt_q[2:0];
    push_o        = 1'b0;
    entry_o       = '0;
    entry_o.kind  = afs_pkg::KindPayload;
    entry_o.len   = flen_q;
    if (accept) begin
      unique case (phase_q)
        afs_pkg::PhHunt: begin
          if (data_i == afs_pkg::SyncByte) begin
            hdr_we  = 1'b1;
            hdr_wa  = 3'd0;
            cnt_d   = LenW'(1);
            phase_d = afs_pkg::PhSync2;
          end
        end
        afs_pkg::PhSync2: begin
          if ((data_i & afs_pkg::SyncMask) == afs_pkg::SyncMask) begin
            hdr_we  = 1'b1;
            hdr_wa  = 3'd1;
            cnt_d   = LenW'(2);
            phase_d = afs_pkg::PhHeader;
          end else begin
            cnt_d   = '0;
            phase_d = afs_pkg::PhHunt;
          end
        end
        afs_pkg::PhHeader: begin
          if (cnt_q >= LenW'(HdrStore) || cnt_q < LenW'(2)) begin
            // last header byte: decode length, drop header if too short
            if (len_dec < afs_pkg::MinLen) begin
              cnt_d   = '0;
              flen_d  = '0;
              phase_d = afs_pkg::PhHunt;
            end else begin
              flen_d        = len_dec;
              cnt_d         = LenW'(afs_pkg::HdrBytes);
              phase_d       = afs_pkg::PhPayload;
              push_o        = 1'b1;
              entry_o.kind  = afs_pkg::KindHeader;
              entry_o.len   = len_dec;
              for (int i = 0; i < HdrStore; i++) begin
                entry_o.bytes[i] = hdr_q[i];
              end
              entry_o.bytes[HdrStore] = data_i;
            end
          end else begin
            hdr_we = 1'b1;
            cnt_d  = cnt_inc;
          end
        end
        afs_pkg::PhPayload: begin
          push_o           = 1'b1;
          entry_o.bytes[0] = data_i;
          entry_o.last     = (cnt_inc >= flen_q);
          if (cnt_inc >= flen_q) begin
            cnt_d   = '0;
            phase_d = afs_pkg::PhHunt;
          end else begin
            cnt_d   = cnt_inc;
          end
        end
        default: begin
          phase_d = afs_pkg::PhHunt;
        end
      endcase
    end
  end

  `AFS_ASSERT(a_payload_len_ok, (phase_q == afs_pkg::PhPayload) |-> (flen_q >= afs_pkg::MinLen), "payload phase with short frame length")
  `AFS_ASSERT(a_no_push_full, push_o |-> !full_i, "entry pushed into full queue")

endmodule

// ----- rtl/core/afs_queue.sv -----
// Small FIFO of decoded entries between front and back ends.
// Depends on afs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module afs_queue #(
  parameter int unsigned Depth = afs_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  afs_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output afs_pkg::entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  afs_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `AFS_ASSERT(a_count_bound, count_q <= CntW'(Depth), "queue fill count above depth")

endmodule

// ----- rtl/core/afs_back.sv -----
// Back end: expands queue entries into output transfers, one byte each.
// Depends on afs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module afs_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  afs_pkg::entry_t          head_i,
  output logic                     pop_o,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [7:0]               byte_o,
  output logic                     first_o,
  output logic                     last_o,
  output logic [afs_pkg::LenW-1:0] len_o
);

  localparam int unsigned IdxW = $clog2(afs_pkg::HdrBytes);

  logic                     valid_q, valid_d;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic [7:0]               byte_q;
  logic                     first_q, last_q;
  logic [afs_pkg::LenW-1:0] len_q;
  logic                     load;
  logic                     is_hdr;

  assign load    = !valid_q || ready_i;
  assign is_hdr  = (head_i.kind == afs_pkg::KindHeader);
  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign first_o = first_q;
  assign last_o  = last_q;
  assign len_o   = len_q;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = q_valid_i;
      if (q_valid_i) begin
        if (is_hdr && idx_q != IdxW'(afs_pkg::HdrBytes - 1)) begin
          idx_d = idx_q + IdxW'(1);
        end else begin
          idx_d = '0;
          pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && q_valid_i) begin
      byte_q  <= is_hdr ? head_i.bytes[idx_q] : head_i.bytes[0];
      first_q <= is_hdr && (idx_q == '0);
      last_q  <= !is_hdr && head_i.last;
      len_q   <= head_i.len;
    end
  end

  `AFS_ASSERT(a_idx_in_header, (idx_q != '0) |-> (q_valid_i && is_hdr), "header index set without header at queue head")

endmodule

// ----- rtl/core/adts_frame_sync.sv -----
// ADTS frame synchroniser, top level: front end, entry queue, back end.
// Depends on afs_pkg, afs_front, afs_queue, afs_back.
//
// Takes an AAC ADTS byte stream, one byte per slave transfer, and hunts for
// the 12-bit sync word (0xFF, then a byte with high nibble 0xF). Header
// bytes 0 to 5 are captured; on byte 5 the 13-bit frame length is decoded.
// A length below 7 drops the header and hunting resumes with the next byte.
// Otherwise the six header bytes go out as six master transfers (tuser high
// on the first), then each later byte is passed out until the frame length
// is reached; tlast marks the final byte. Every transfer of a frame carries
// the frame length. Bytes outside a frame produce nothing.
// Rate: one byte accepted per cycle, results leave at one per cycle, while
// the queue has room and the master side is ready. The back end expands a
// header entry into six transfers, absorbed by the QueueDepth-entry queue
// (eight by default) so a stream of valid frames runs at one byte per cycle.
// Each byte passes through the queue and the registered output stage.
module adts_frame_sync #(
  parameter int unsigned QueueDepth = afs_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [20:8] frame_length, [23:21] zero
  output logic        m_axis_tuser,   // [0] frame_first
  output logic        m_axis_tlast    // frame_last
);

  logic                     q_full;
  logic                     q_push;
  logic                     q_pop;
  logic                     q_valid;
  afs_pkg::entry_t          q_in;
  afs_pkg::entry_t          q_head;
  logic [7:0]               out_byte;
  logic [afs_pkg::LenW-1:0] out_len;

  // Front end: sync hunt and header decode
  afs_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata),
    .full_i  (q_full),
    .push_o  (q_push),
    .entry_o (q_in)
  );

  // Decouples the header burst from the incoming byte stream
  afs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  // Back end: registered output stage
  afs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .head_i    (q_head),
    .pop_o     (q_pop),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .byte_o    (out_byte),
    .first_o   (m_axis_tuser),
    .last_o    (m_axis_tlast),
    .len_o     (out_len)
  );

  assign m_axis_tdata = {3'b000, out_len, out_byte};

endmodule
